// File: hw/rtl/can_bit_timing_solver_macros.svh
// Assertion macros shared by the bit timing solver modules.
`ifndef CAN_BIT_TIMING_SOLVER_MACROS_SVH
`define CAN_BIT_TIMING_SOLVER_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define CBTS_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define CBTS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define CBTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/cbts_pkg.sv
// Types, constants and codes of the CAN bit timing solver.
`default_nettype none

package cbts_pkg;

	// Field widths.
	localparam int CLOCK_W = 32;
	localparam int RATE_W  = 20;
	localparam int PRE_CODE_W  = 7;
	localparam int SEG_CODE_W  = 3;
	localparam int JUMP_CODE_W = 2;
	localparam int STATUS_W    = 2;

	// Divider width and its step counter width.
	localparam int DIV_W = CLOCK_W;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	// Default upper end of the prescaler search.
	localparam int CBTS_MAX_PRESCALER = 128;

	// Limits of the timing rules.
	localparam logic [DIV_W-1:0] PRE_ENC_MAX  = DIV_W'(128);
	localparam logic [DIV_W-1:0] QS_MIN       = DIV_W'(5);
	localparam logic [DIV_W-1:0] QS_MAX       = DIV_W'(20);
	localparam logic [DIV_W-1:0] PH_SEARCH_MAX = DIV_W'(7);
	localparam logic [DIV_W-1:0] PH_ENC_MAX   = DIV_W'(8);
	localparam logic [DIV_W-1:0] FB_DIVISOR   = DIV_W'(10);
	localparam logic [DIV_W-1:0] SYNC_PROP_Q  = DIV_W'(2);
	localparam logic [DIV_W-1:0] FB_CAP_SPAN  = DIV_W'(9);
	localparam int SEG_SHIFT = 3;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_FOUND    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FALLBACK = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd2;

	// Fixed segment codes.
	localparam logic [SEG_CODE_W-1:0]  PROP_CODE = 3'd0;
	localparam logic [JUMP_CODE_W-1:0] JUMP_CODE = 2'd1;

	typedef struct packed {
		logic [CLOCK_W-1:0] clock_hz;
		logic [RATE_W-1:0]  bit_rate;
	} request_t;

	typedef struct packed {
		logic [PRE_CODE_W-1:0]  prescaler_code;
		logic [SEG_CODE_W-1:0]  propagation_code;
		logic [SEG_CODE_W-1:0]  phase_one_code;
		logic [SEG_CODE_W-1:0]  phase_two_code;
		logic [JUMP_CODE_W-1:0] jump_width_code;
		logic [STATUS_W-1:0]    status;
	} result_t;

	// Divider response towards the sequencer.
	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
		logic [DIV_W-1:0] remainder;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_WAIT,
		ST_DONE
	} cbts_state_t;

	// Which division the shared divider is working on.
	typedef enum logic [1:0] {
		OP_RATE,
		OP_TRY,
		OP_TEN,
		OP_FALLBACK
	} div_op_t;

	function automatic result_t invalid_result();
		result_t r;
		r.prescaler_code   = '0;
		r.propagation_code = PROP_CODE;
		r.phase_one_code   = '0;
		r.phase_two_code   = '0;
		r.jump_width_code  = JUMP_CODE;
		r.status           = STATUS_INVALID;
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cbts_stream_if.sv
// Valid/ready stream interface carrying one payload per transaction.
`default_nettype none

interface cbts_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/cbts_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
`include "can_bit_timing_solver_macros.svh"

module cbts_div import cbts_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [DIV_W-1:0] divisor,
	output div_rsp_t              rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] count_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     divisor_q;
	logic [DIV_W:0]       rem_shift;
	logic [DIV_W:0]       diff;
	logic                 borrow;

	// One trial subtraction of the shifted partial remainder.
	always_comb begin
		rem_shift = {rem_q, quo_q[DIV_W-1]};
		diff      = rem_shift - {1'b0, divisor_q};
		borrow    = diff[DIV_W];
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				count_q <= DIV_CNT_W'(DIV_W);
			end else if (busy_q) begin
				count_q <= count_q - DIV_CNT_W'(1);
				if (count_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial remainder registers.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q     <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ~borrow};
			rem_q <= borrow ? rem_shift[DIV_W-1:0] : diff[DIV_W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

	`CBTS_ASSERT_SAME(a_no_restart, start, !busy_q, "divider started while busy")
	`CBTS_ASSERT_NEXT(a_last_step, busy_q && !start && count_q == DIV_CNT_W'(1),
		done_q && !busy_q, "divider did not finish after its last step")
	`CBTS_ASSERT_NEXT(a_done_pulse, done_q, !done_q, "divider done held longer than a cycle")

endmodule

`default_nettype wire

// File: hw/rtl/can_bit_timing_solver.sv
// CAN bit timing solver: one request transaction gives the clock frequency and the target bit
// rate, one result transaction returns the prescaler and segment codes with a status. A single
// 32-bit iterative divider does all the arithmetic under a small sequencer. A request needs at
// most the rate division, MAX_PRESCALER trial divisions and two fallback divisions before the
// block is ready again; the search stops early once the trial quotient falls below five quanta,
// and a zero bit rate is answered without any division. The block takes one request at a time;
// a new request is accepted while the previous result still waits in the output register.
`default_nettype none
`include "can_bit_timing_solver_macros.svh"

module can_bit_timing_solver import cbts_pkg::*; #(
	parameter int MAX_PRESCALER = CBTS_MAX_PRESCALER
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	cbts_stream_if.sink    request,
	cbts_stream_if.source  result
);

	localparam int PRE_W = $clog2(MAX_PRESCALER + 1);

	cbts_state_t        state_q, state_d;
	div_op_t            op_q;
	logic [PRE_W-1:0]   pre_q;
	logic [7:0]         fbpre_q;
	logic [CLOCK_W-1:0] clock_q;
	logic [RATE_W-1:0]  rate_q;
	logic [DIV_W-1:0]   tq_q;
	result_t            pend_q;
	result_t            out_q;
	logic               out_valid_q;

	logic             accept;
	logic             slot_free;
	logic             div_start;
	logic             load_out;
	logic [DIV_W-1:0] div_dividend;
	logic [DIV_W-1:0] div_divisor;
	div_rsp_t         div_rsp;

	logic [DIV_W-1:0] q;
	logic [DIV_W-1:0] pre_wide;
	logic [DIV_W-1:0] pre_minus;
	logic [DIV_W-1:0] tr_ph2;
	logic [DIV_W-1:0] tr_ph1;
	logic             try_hit;
	logic             try_enc;
	logic             try_stop;
	logic             ten_bad;
	logic [DIV_W-1:0] fb_ph2a;
	logic [DIV_W-1:0] fb_ph1a;
	logic [DIV_W-1:0] fb_ph1;
	logic [DIV_W-1:0] fb_ph2;
	logic [DIV_W-1:0] fb_ph1_m;
	logic [DIV_W-1:0] fb_ph2_m;
	logic [DIV_W-1:0] tr_ph1_m;
	logic [DIV_W-1:0] tr_ph2_m;
	logic             fb_ok;

	assign accept    = request.valid && request.ready;
	assign slot_free = !out_valid_q || result.ready;

	// Shared divider and its operand selection.
	always_comb begin
		div_dividend = tq_q;
		div_divisor  = FB_DIVISOR;
		case (op_q)
			OP_RATE: begin
				div_dividend = clock_q;
				div_divisor  = DIV_W'(rate_q);
			end
			OP_TRY:      div_divisor = DIV_W'(pre_q);
			OP_TEN:      div_divisor = FB_DIVISOR;
			OP_FALLBACK: div_divisor = DIV_W'(fbpre_q);
			default:     div_divisor = FB_DIVISOR;
		endcase
	end

	cbts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.rsp      (div_rsp)
	);

	// Checks on the trial quotient of the prescaler search.
	always_comb begin
		q         = div_rsp.quotient;
		pre_wide  = DIV_W'(pre_q);
		pre_minus = pre_wide - DIV_W'(1);
		tr_ph2    = q >> SEG_SHIFT;
		tr_ph1    = q - tr_ph2 - SYNC_PROP_Q;
		tr_ph1_m  = tr_ph1 - DIV_W'(1);
		tr_ph2_m  = tr_ph2 - DIV_W'(1);
		try_hit   = (div_rsp.remainder == '0) && (q >= QS_MIN) && (q <= QS_MAX) &&
			(tr_ph1 != '0) && (tr_ph1 <= PH_SEARCH_MAX) &&
			(tr_ph2 != '0) && (tr_ph2 <= PH_SEARCH_MAX);
		try_enc   = pre_wide <= PRE_ENC_MAX;
		try_stop  = (q < QS_MIN) || (pre_q == PRE_W'(MAX_PRESCALER));
		ten_bad   = (q == '0) || (q > PRE_ENC_MAX);
	end

	// Fallback segments from the quanta per prescaled bit.
	always_comb begin
		fb_ph2a = q >> SEG_SHIFT;
		fb_ph1a = q - fb_ph2a - SYNC_PROP_Q;
		if (fb_ph1a > PH_SEARCH_MAX) begin
			fb_ph1 = PH_SEARCH_MAX;
			fb_ph2 = q - FB_CAP_SPAN;
		end else begin
			fb_ph1 = fb_ph1a;
			fb_ph2 = fb_ph2a;
		end
		fb_ph1_m = fb_ph1 - DIV_W'(1);
		fb_ph2_m = fb_ph2 - DIV_W'(1);
		fb_ok    = (q >= fb_ph2a + SYNC_PROP_Q) &&
			(fb_ph1 != '0) && (fb_ph1 <= PH_ENC_MAX) &&
			(fb_ph2 != '0) && (fb_ph2 <= PH_ENC_MAX);
	end

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (request.payload.bit_rate == '0) ? ST_DONE : ST_START;
				end
			end
			ST_START: state_d = ST_WAIT;
			ST_WAIT: begin
				if (div_rsp.done) begin
					case (op_q)
						OP_RATE:     state_d = ST_START;
						OP_TRY:      state_d = try_hit ? ST_DONE : ST_START;
						OP_TEN:      state_d = ten_bad ? ST_DONE : ST_START;
						OP_FALLBACK: state_d = ST_DONE;
						default:     state_d = ST_DONE;
					endcase
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		request.ready = 1'b0;
		div_start     = 1'b0;
		load_out      = 1'b0;
		case (state_q)
			ST_IDLE:  request.ready = 1'b1;
			ST_START: div_start = 1'b1;
			ST_WAIT:  ;
			ST_DONE:  load_out = slot_free;
			default:  ;
		endcase
	end

	// Sequencer state, division selector and prescaler counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_RATE;
			pre_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_q <= OP_RATE;
			end else if (state_q == ST_WAIT && div_rsp.done) begin
				case (op_q)
					OP_RATE: begin
						op_q  <= OP_TRY;
						pre_q <= PRE_W'(1);
					end
					OP_TRY: begin
						if (!try_hit) begin
							if (try_stop) begin
								op_q <= OP_TEN;
							end else begin
								pre_q <= pre_q + PRE_W'(1);
							end
						end
					end
					OP_TEN:      op_q <= OP_FALLBACK;
					OP_FALLBACK: op_q <= OP_RATE;
					default:     op_q <= OP_RATE;
				endcase
			end
		end
	end

	// Operands, quanta count and pending result.
	always_ff @(posedge clk) begin
		if (accept) begin
			clock_q <= request.payload.clock_hz;
			rate_q  <= request.payload.bit_rate;
			pend_q  <= invalid_result();
		end else if (state_q == ST_WAIT && div_rsp.done) begin
			case (op_q)
				OP_RATE: tq_q <= q;
				OP_TRY: begin
					if (try_hit && try_enc) begin
						pend_q.prescaler_code <= pre_minus[PRE_CODE_W-1:0];
						pend_q.phase_one_code <= tr_ph1_m[SEG_CODE_W-1:0];
						pend_q.phase_two_code <= tr_ph2_m[SEG_CODE_W-1:0];
						pend_q.status         <= STATUS_FOUND;
					end
				end
				OP_TEN: fbpre_q <= q[7:0];
				OP_FALLBACK: begin
					if (fb_ok) begin
						pend_q.prescaler_code <= PRE_CODE_W'(fbpre_q - 8'd1);
						pend_q.phase_one_code <= fb_ph1_m[SEG_CODE_W-1:0];
						pend_q.phase_two_code <= fb_ph2_m[SEG_CODE_W-1:0];
						pend_q.status         <= STATUS_FALLBACK;
					end
				end
				default: ;
			endcase
		end
	end

	// Output register: the result waits here until its transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= pend_q;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	`CBTS_ASSERT_SAME(a_invalid_zero, out_valid_q && out_q.status == STATUS_INVALID,
		out_q.prescaler_code == '0 && out_q.phase_one_code == '0 &&
		out_q.phase_two_code == '0, "invalid result carries nonzero codes")
	`CBTS_ASSERT_SAME(a_found_segments, out_valid_q && out_q.status == STATUS_FOUND,
		out_q.phase_two_code == '0 && (out_q.phase_one_code == 3'd4 ||
		out_q.phase_one_code == 3'd5 || out_q.phase_one_code == 3'd6),
		"search result has segments outside the sample point rule")
	`CBTS_ASSERT_SAME(a_done_in_wait, div_rsp.done, state_q == ST_WAIT,
		"divider finished outside the wait state")
	`CBTS_ASSERT_NEXT(a_start_rate, accept && request.payload.bit_rate != '0,
		state_q == ST_START && op_q == OP_RATE, "request did not start the rate division")

endmodule

`default_nettype wire
